// ----- rtl/cht_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cht_pkg: shared constants and types of the chained hash table.
// Operation and status codes and the default table dimensions.
// ----------------------------------------------------------------------------
package cht_pkg;

    localparam int NumBucketsDefault = 11;
    localparam int MaxEntriesDefault = 64;

    typedef enum logic [1:0] {
        FUNC_INSERT   = 2'd0,
        FUNC_REMOVE   = 2'd1,
        FUNC_CONTAINS = 2'd2,
        FUNC_GET      = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_NOT_FOUND = 2'd2
    } t_status;

endpackage
`default_nettype wire

// ----- rtl/cht_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cht_ram: generic single-port-write, single-port-read RAM.
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module cht_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic      [Width-1:0]         o_rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- rtl/chained_hash_table_engine.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// chained_hash_table_engine: hash table with separate chaining.
// Entries live in a RAM (key, data, link); bucket heads and tails and the
// used bits are flip-flops.
//
//   channel | signals                                      | direction
//   command | i_start, o_busy, i_func, i_key_*, i_data_in  | in
//   result  | o_valid, o_found, o_data_out, o_status,      | out
//           | o_entry_count                                |
//
// After acceptance o_busy stays high in QUOT (quotient), MOD (remainder and
// head fetch), PLAN and DONE, plus READ, CHECK per chain entry read, plus READ,
// FIX when a link is rewritten (insert into a non-empty bucket, remove of an
// entry that is not the head). The result strobe follows in the next cycle.
// The bucket is the key sum modulo NUM_BUCKETS by reciprocal multiplication.
// Reset is synchronous and empties all buckets at once; no clearing pass.
// The receiver cannot stall; each result shows for one cycle.
// ----------------------------------------------------------------------------
module chained_hash_table_engine #(
    parameter int NUM_BUCKETS = cht_pkg::NumBucketsDefault,
    parameter int MAX_ENTRIES = cht_pkg::MaxEntriesDefault
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [1:0]  i_func,
    input  wire logic [15:0] i_key_a,
    input  wire logic [15:0] i_key_b,
    input  wire logic [15:0] i_key_c,
    input  wire logic signed [31:0] i_data_in,
    output logic             o_valid,
    output logic             o_found,
    output logic signed [31:0] o_data_out,
    output logic [1:0]       o_status,
    output logic [6:0]       o_entry_count
);
    localparam int AW  = $clog2(MAX_ENTRIES);
    localparam int LW  = $clog2(MAX_ENTRIES + 1);
    localparam int BW  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int SW  = 18;
    localparam int EW  = 48 + 32 + LW;
    localparam int KSH = SW + $clog2(NUM_BUCKETS);
    localparam int RW  = SW + 1;
    localparam logic [LW-1:0] NIL = LW'(MAX_ENTRIES);
    localparam logic [SW-1:0] NB  = SW'(NUM_BUCKETS);
    localparam logic [RW-1:0] RECIP = RW'(((longint'(1) << KSH)
                                           + longint'(NUM_BUCKETS) - longint'(1))
                                          / longint'(NUM_BUCKETS));

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_QUOT  = 8'b00000010,
        S_MOD   = 8'b00000100,
        S_PLAN  = 8'b00001000,
        S_READ  = 8'b00010000,
        S_CHECK = 8'b00100000,
        S_FIX   = 8'b01000000,
        S_DONE  = 8'b10000000
    } t_state;

    t_state r_state;
    logic [1:0]  r_func;
    logic [47:0] r_key;
    logic [31:0] r_data;
    logic [SW-1:0] r_sum;
    logic [SW-1:0] r_quot;
    logic [LW-1:0] r_cur, r_prev;
    logic [LW-1:0] r_head [NUM_BUCKETS];
    logic [LW-1:0] r_tail [NUM_BUCKETS];
    logic [MAX_ENTRIES-1:0] r_used;
    logic [LW-1:0] r_count;
    logic [LW-1:0] r_next;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [EW-1:0] wdata, rdata;

    logic [SW+RW-1:0] recip_prod;
    logic [SW-1:0]    quot_w, quot_x_nb, rem_w;

    cht_ram #(.Width(EW), .Depth(MAX_ENTRIES)) u_entries (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    wire [BW-1:0] bkt = BW'(r_sum);
    wire [47:0] rd_key  = rdata[EW-1 -: 48];
    wire [31:0] rd_data = rdata[LW +: 32];
    wire [LW-1:0] rd_link = rdata[LW-1:0];

    // The quotient is exact for any sum below 2**18; the remainder is then taken
    // in state MOD from the registered quotient.
    assign recip_prod = (SW+RW)'(r_sum) * (SW+RW)'(RECIP);
    assign quot_w     = SW'(recip_prod >> KSH);
    assign quot_x_nb  = r_quot * NB;
    assign rem_w      = r_sum - quot_x_nb;
    wire [BW-1:0] rem_bkt = BW'(rem_w);

    // Lowest free slot.
    logic [LW-1:0] free_slot;
    always_comb begin
        free_slot = NIL;
        for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_slot = LW'(i);
            end
        end
    end

    always_comb begin
        raddr = AW'(r_cur);
        we    = 1'b0;
        waddr = AW'(r_cur);
        wdata = {r_key, r_data, NIL};
        if (r_state == S_PLAN && cht_pkg::t_func'(r_func) == cht_pkg::FUNC_INSERT
            && free_slot != NIL) begin
            we    = 1'b1;
            waddr = AW'(free_slot);
        end
        // Relink the predecessor or the old tail: rewrite its key and data too,
        // held in the re-read entry.
        if (r_state == S_FIX) begin
            we    = 1'b1;
            waddr = AW'(r_prev);
            wdata = {rdata[EW-1:LW], r_next};
        end
    end

    assign o_busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        o_valid <= 1'b0;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_count <= '0;
            for (int b = 0; b < NUM_BUCKETS; b++) begin
                r_head[b] <= NIL;
                r_tail[b] <= NIL;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_func  <= i_func;
                        r_key   <= {i_key_c, i_key_b, i_key_a};
                        r_data  <= i_data_in;
                        r_sum   <= SW'(i_key_a) + SW'(i_key_b) + SW'(i_key_c);
                        r_state <= S_QUOT;
                    end
                end
                S_QUOT: begin
                    r_quot  <= quot_w;
                    r_state <= S_MOD;
                end
                S_MOD: begin
                    r_sum   <= rem_w;
                    r_cur   <= r_head[rem_bkt];
                    r_prev  <= NIL;
                    r_state <= S_PLAN;
                end
                S_PLAN: begin
                    if (cht_pkg::t_func'(r_func) == cht_pkg::FUNC_INSERT) begin
                        if (free_slot == NIL) begin
                            o_status <= cht_pkg::STATUS_FULL;
                            r_state  <= S_DONE;
                        end else begin
                            r_used[AW'(free_slot)] <= 1'b1;
                            r_count <= r_count + 1'b1;
                            r_tail[bkt] <= free_slot;
                            o_status <= cht_pkg::STATUS_OK;
                            if (r_tail[bkt] == NIL) begin
                                r_head[bkt] <= free_slot;
                                r_state <= S_DONE;
                            end else begin
                                r_prev  <= r_tail[bkt];
                                r_cur   <= r_tail[bkt];
                                r_next  <= free_slot;
                                r_state <= S_READ;
                            end
                        end
                        o_found    <= 1'b0;
                        o_data_out <= '0;
                    end else if (r_cur == NIL) begin
                        o_found    <= 1'b0;
                        o_data_out <= '0;
                        o_status   <= cht_pkg::STATUS_NOT_FOUND;
                        r_state    <= S_DONE;
                    end else begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= (cht_pkg::t_func'(r_func) == cht_pkg::FUNC_INSERT)
                               ? S_FIX : S_CHECK;
                end
                S_CHECK: begin
                    if (rd_key == r_key) begin
                        o_found  <= 1'b1;
                        o_status <= cht_pkg::STATUS_OK;
                        o_data_out <= (cht_pkg::t_func'(r_func) == cht_pkg::FUNC_GET)
                                      ? rd_data : '0;
                        if (cht_pkg::t_func'(r_func) == cht_pkg::FUNC_REMOVE) begin
                            r_used[AW'(r_cur)] <= 1'b0;
                            r_count <= r_count - 1'b1;
                            if (r_tail[bkt] == r_cur) begin
                                r_tail[bkt] <= r_prev;
                            end
                            if (r_prev == NIL) begin
                                r_head[bkt] <= rd_link;
                                r_state <= S_DONE;
                            end else begin
                                r_next  <= rd_link;
                                r_cur   <= r_prev;
                                r_state <= S_READ;
                            end
                        end else begin
                            r_state <= S_DONE;
                        end
                    end else if (rd_link == NIL) begin
                        o_found    <= 1'b0;
                        o_data_out <= '0;
                        o_status   <= cht_pkg::STATUS_NOT_FOUND;
                        r_state    <= S_DONE;
                    end else begin
                        r_prev  <= r_cur;
                        r_cur   <= rd_link;
                        r_state <= S_READ;
                    end
                end
                S_FIX: begin
                    // The write port rewrites the re-read entry with its new link.
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    o_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
            // A remove that must relink its predecessor goes through READ then
            // FIX like an insert.
            if (r_state == S_CHECK && rd_key == r_key
                && cht_pkg::t_func'(r_func) == cht_pkg::FUNC_REMOVE && r_prev != NIL) begin
                r_func <= cht_pkg::FUNC_INSERT;
            end
        end
    end

    assign o_entry_count = 7'(r_count);
endmodule
`default_nettype wire
